// File: rtl/core/bbe_pkg.sv
// ----------------------------------------------------------------------------
// bbe_pkg
// shared constants, codes and types of the bezier blossom evaluator
// ----------------------------------------------------------------------------
package bbe_pkg;

    localparam int MAX_POINTS = 8;
    localparam int PIDX_W     = $clog2(MAX_POINTS);
    localparam int PCNT_W     = 4;
    localparam int LEN_W      = $clog2(MAX_POINTS + 1);

    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_VALUE  = 2'd1,
        FUNC_BOUNDS = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        FOP_ADD,
        FOP_SUB,
        FOP_MUL
    } t_fop;

    typedef struct packed {
        logic start;
        t_fop op;
    } t_fpu_req;

    typedef enum logic [2:0] {
        F_IDLE,
        F_PREP,
        F_ADD,
        F_MUL,
        F_NORM,
        F_ROUND,
        F_DONE
    } t_fstate;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COPY,
        S_SUB,
        S_MUL,
        S_ADD,
        S_DROP,
        S_HULL,
        S_OUT
    } t_state;

endpackage

// File: rtl/core/bbe_fpu.sv
// ----------------------------------------------------------------------------
// bbe_fpu
// iterative double add, subtract and multiply, round to nearest even
// ----------------------------------------------------------------------------
module bbe_fpu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bbe_pkg::t_fpu_req i_req,
    input  logic [63:0]       i_x,
    input  logic [63:0]       i_y,
    output logic              o_done,
    output logic [63:0]       o_res
);
    import bbe_pkg::*;

    t_fstate            r_state, n_state;
    t_fop               r_op;
    logic [63:0]        r_x, r_y, r_res;
    logic [107:0]       r_w, r_wb;
    logic signed [12:0] r_e;
    logic               r_sign, r_zsign, r_eff_sub;
    logic [52:0]        r_mplier, r_mcand;
    logic [5:0]         r_cnt;

    // operand decode
    logic        ys_eff, x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
    logic        special;
    logic [63:0] spec_res;
    logic [10:0] ex, ey;
    logic [52:0] mx, my;

    // add path
    logic        swap, s_l, s_s;
    logic [10:0] e_l, e_s, d_al;
    logic [52:0] m_l, m_s;
    logic [107:0] base_s, aligned;

    // multiply path
    logic signed [12:0] e_mul;
    logic [53:0]        sum54;

    // normalize and round
    logic        w_zero;
    logic [12:0] den_amt;
    logic [107:0] den_w;
    logic        up;
    logic [53:0] mr;
    logic signed [12:0] e2;
    logic [63:0] rnd_res;

    always_comb begin
        ys_eff = (r_op == FOP_SUB) ? ~r_y[63] : r_y[63];
        x_nan  = (&r_x[62:52]) & (|r_x[51:0]);
        y_nan  = (&r_y[62:52]) & (|r_y[51:0]);
        x_inf  = (&r_x[62:52]) & ~(|r_x[51:0]);
        y_inf  = (&r_y[62:52]) & ~(|r_y[51:0]);
        x_zero = ~(|r_x[62:0]);
        y_zero = ~(|r_y[62:0]);
        ex     = (r_x[62:52] == 11'd0) ? 11'd1 : r_x[62:52];
        ey     = (r_y[62:52] == 11'd0) ? 11'd1 : r_y[62:52];
        mx     = {|r_x[62:52], r_x[51:0]};
        my     = {|r_y[62:52], r_y[51:0]};

        special  = 1'b1;
        spec_res = DEFAULT_NAN;
        if (x_nan) begin
            spec_res = r_x | 64'h0008_0000_0000_0000;
        end else if (y_nan) begin
            spec_res = r_y | 64'h0008_0000_0000_0000;
        end else if (r_op == FOP_MUL) begin
            if (x_inf || y_inf) begin
                spec_res = (x_zero || y_zero) ? DEFAULT_NAN
                         : {r_x[63] ^ r_y[63], 11'h7FF, 52'd0};
            end else if (x_zero || y_zero) begin
                spec_res = {r_x[63] ^ r_y[63], 63'd0};
            end else begin
                special = 1'b0;
            end
        end else begin
            if (x_inf && y_inf) begin
                spec_res = (r_x[63] == ys_eff) ? r_x : DEFAULT_NAN;
            end else if (x_inf) begin
                spec_res = r_x;
            end else if (y_inf) begin
                spec_res = {ys_eff, 11'h7FF, 52'd0};
            end else begin
                special = 1'b0;
            end
        end

        // larger magnitude first so the difference stays positive
        swap    = r_y[62:0] > r_x[62:0];
        s_l     = swap ? ys_eff : r_x[63];
        s_s     = swap ? r_x[63] : ys_eff;
        e_l     = swap ? ey : ex;
        e_s     = swap ? ex : ey;
        m_l     = swap ? my : mx;
        m_s     = swap ? mx : my;
        d_al    = e_l - e_s;
        base_s  = {1'b0, m_s, 54'd0};
        aligned = (base_s >> d_al)
                | {107'd0, |(base_s & ~({108{1'b1}} << d_al))};

        e_mul = $signed({2'b00, ex}) + $signed({2'b00, ey}) - 13'sd1023;
        sum54 = {1'b0, r_w[107:55]} + {1'b0, (r_mplier[0] ? r_mcand : 53'd0)};

        w_zero  = ~(|r_w);
        den_amt = 13'sd1 - r_e;
        den_w   = (r_w >> den_amt[10:0])
                | {107'd0, |(r_w & ~({108{1'b1}} << den_amt[10:0]))};

        up = r_w[53] & ((|r_w[52:0]) | r_w[54]);
        mr = {1'b0, r_w[106:54]} + {53'd0, up};
        e2 = r_e + $signed({12'd0, mr[53]});
        if (e2 >= 13'sd2047) begin
            rnd_res = {r_sign, 11'h7FF, 52'd0};
        end else begin
            rnd_res = {r_sign,
                       (mr[53] | mr[52]) ? e2[10:0] : 11'd0,
                       mr[53] ? 52'd0 : mr[51:0]};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (i_req.start) n_state = F_PREP;
            F_PREP: begin
                if (special)              n_state = F_DONE;
                else if (r_op == FOP_MUL) n_state = F_MUL;
                else                      n_state = F_ADD;
            end
            F_ADD:   n_state = F_NORM;
            F_MUL:   if (r_cnt == 6'd1) n_state = F_NORM;
            F_NORM: begin
                if (w_zero) begin
                    n_state = F_DONE;
                end else if (!r_w[107] && !(!r_w[106] && r_e > 13'sd1)
                             && !(r_e < 13'sd1)) begin
                    n_state = F_ROUND;
                end
            end
            F_ROUND: n_state = F_DONE;
            F_DONE:  n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_done = (r_state == F_DONE);
        o_res  = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (i_req.start) begin
                    r_x  <= i_x;
                    r_y  <= i_y;
                    r_op <= i_req.op;
                end
            end
            F_PREP: begin
                r_res <= spec_res;
                if (r_op == FOP_MUL) begin
                    r_w      <= '0;
                    r_mplier <= mx;
                    r_mcand  <= my;
                    r_cnt    <= 6'd53;
                    r_e      <= e_mul;
                    r_sign   <= r_x[63] ^ r_y[63];
                    r_zsign  <= 1'b0;
                end else begin
                    r_w       <= {1'b0, m_l, 54'd0};
                    r_wb      <= aligned;
                    r_e       <= $signed({2'b00, e_l});
                    r_sign    <= s_l;
                    r_eff_sub <= s_l ^ s_s;
                    r_zsign   <= (x_zero && y_zero) ? (r_x[63] & ys_eff) : 1'b0;
                end
            end
            F_ADD: begin
                r_w <= r_eff_sub ? (r_w - r_wb) : (r_w + r_wb);
            end
            F_MUL: begin
                // one multiplier bit a cycle, partial sum shifted right
                r_w[107:55] <= sum54[53:1];
                r_w[54:2]   <= {sum54[0], r_w[54:3]};
                r_mplier    <= r_mplier >> 1;
                r_cnt       <= r_cnt - 6'd1;
            end
            F_NORM: begin
                if (w_zero) begin
                    r_res <= {r_zsign, 63'd0};
                end else if (r_w[107]) begin
                    r_w <= {1'b0, r_w[107:2], r_w[1] | r_w[0]};
                    r_e <= r_e + 13'sd1;
                end else if (!r_w[106] && r_e > 13'sd1) begin
                    if (~(|r_w[106:99]) && r_e > 13'sd8) begin
                        r_w <= r_w << 8;
                        r_e <= r_e - 13'sd8;
                    end else begin
                        r_w <= r_w << 1;
                        r_e <= r_e - 13'sd1;
                    end
                end else if (r_e < 13'sd1) begin
                    r_w <= den_w;
                    r_e <= 13'sd1;
                end
            end
            F_ROUND: begin
                r_res <= rnd_res;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/core/bezier_blossom_evaluator_unit.sv
// ----------------------------------------------------------------------------
// bezier_blossom_evaluator_unit
// de casteljau evaluation and blossom hull bounds of a double bezier curve
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_func, i_point_index,
//                                            i_point_value, i_t_lower, i_t_upper
//  result    out        o_valid / i_ready    o_result_lower, o_result_upper
//  config    in         i_cfg_wr_en          i_cfg_wr_data (point count)
//
//  a lerp is three passes through the shared fpu (subtract, multiply, add),
//  the multiply being a 53-step shift-add
//  value runs one de casteljau collapse, bounds runs n of them for n points
//  reset is synchronous active low; control points are not cleared
//  a finished result waits in the output register, new beats are taken meanwhile
// ----------------------------------------------------------------------------
module bezier_blossom_evaluator_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_func,
    input  logic [2:0]            i_point_index,
    input  logic [63:0]           i_point_value,
    input  logic [63:0]           i_t_lower,
    input  logic [63:0]           i_t_upper,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [63:0]           o_result_lower,
    output logic [63:0]           o_result_upper,
    input  logic                  i_cfg_wr_en,
    input  logic [3:0]            i_cfg_wr_data
);
    import bbe_pkg::*;

    // ieee less-than, false on nan, zeros equal
    function automatic logic f_lt(input logic [63:0] a, input logic [63:0] b);
        logic a_nan, b_nan, r;
        a_nan = (&a[62:52]) & (|a[51:0]);
        b_nan = (&b[62:52]) & (|b[51:0]);
        if (a_nan || b_nan)                 r = 1'b0;
        else if (~(|a[62:0]) && ~(|b[62:0])) r = 1'b0;
        else if (a[63] != b[63])            r = a[63];
        else if (!a[63])                    r = a[62:0] < b[62:0];
        else                                r = a[62:0] > b[62:0];
        return r;
    endfunction

    t_state              r_state, n_state;
    logic [63:0]         r_cp [MAX_POINTS];
    logic [63:0]         r_q  [MAX_POINTS];
    logic [PCNT_W-1:0]   r_pcnt;
    logic [LEN_W-1:0]    r_n, r_len;
    logic [PIDX_W-1:0]   r_m, r_i, r_hull;
    logic [63:0]         r_lo, r_hi, r_tmp, r_mn, r_mx;
    logic                r_bounds;
    logic                r_ovalid;
    logic [63:0]         r_olo, r_ohi;

    logic [LEN_W-1:0]    n_pts;
    logic                in_acc, out_free;
    logic [63:0]         t_sel;
    t_fpu_req            fpu_req;
    logic [63:0]         fpu_x, fpu_y, fpu_res;
    logic                fpu_done;

    // clamp point count to the supported range
    always_comb begin
        if (r_pcnt < PCNT_W'(2))               n_pts = LEN_W'(2);
        else if (r_pcnt > PCNT_W'(MAX_POINTS)) n_pts = LEN_W'(MAX_POINTS);
        else                                   n_pts = LEN_W'(r_pcnt);
    end

    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    // the last r_hull stages run at t_lower
    assign t_sel    = (r_m <= r_hull) ? r_lo : r_hi;

    bbe_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .i_x     (fpu_x),
        .i_y     (fpu_y),
        .o_done  (fpu_done),
        .o_res   (fpu_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_func == FUNC_VALUE || i_func == FUNC_BOUNDS)) begin
                    n_state = S_COPY;
                end
            end
            S_COPY:  n_state = S_SUB;
            S_SUB:   if (fpu_done) n_state = S_MUL;
            S_MUL:   if (fpu_done) n_state = S_ADD;
            S_ADD: begin
                if (fpu_done) begin
                    n_state = (r_i + PIDX_W'(1) == r_m) ? S_DROP : S_SUB;
                end
            end
            S_DROP:  n_state = (r_m == PIDX_W'(1)) ? S_HULL : S_SUB;
            S_HULL: begin
                if (!r_bounds || (LEN_W'(r_hull) + LEN_W'(1) == r_n)) n_state = S_OUT;
                else                                                   n_state = S_COPY;
            end
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and fpu operand steering
    always_comb begin
        o_ready        = (r_state == S_IDLE);
        o_valid        = r_ovalid;
        o_result_lower = r_olo;
        o_result_upper = r_ohi;
        fpu_req.start  = 1'b0;
        fpu_req.op     = FOP_ADD;
        fpu_x          = r_q[0];
        fpu_y          = r_tmp;
        unique case (r_state)
            S_SUB: begin
                fpu_req.start = 1'b1;
                fpu_req.op    = FOP_SUB;
                fpu_x         = r_q[1];
                fpu_y         = r_q[0];
            end
            S_MUL: begin
                fpu_req.start = 1'b1;
                fpu_req.op    = FOP_MUL;
                fpu_x         = t_sel;
                fpu_y         = r_tmp;
            end
            S_ADD: begin
                fpu_req.start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pcnt   <= PCNT_W'(4);
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_pcnt <= i_cfg_wr_data;
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_func == FUNC_LOAD) r_cp[i_point_index] <= i_point_value;
                    r_lo     <= i_t_lower;
                    r_hi     <= (i_func == FUNC_BOUNDS) ? i_t_upper : i_t_lower;
                    r_bounds <= (i_func == FUNC_BOUNDS);
                    r_n      <= n_pts;
                    r_hull   <= '0;
                end
            end
            S_COPY: begin
                for (int k = 0; k < MAX_POINTS; k++) r_q[k] <= r_cp[k];
                r_len <= r_n;
                r_m   <= PIDX_W'(r_n - LEN_W'(1));
                r_i   <= '0;
            end
            S_SUB, S_MUL: begin
                if (fpu_done) r_tmp <= fpu_res;
            end
            S_ADD: begin
                if (fpu_done) begin
                    // pop the head, new point goes to the tail of the stage
                    for (int k = 0; k < MAX_POINTS - 1; k++) r_q[k] <= r_q[k + 1];
                    r_q[PIDX_W'(r_len - LEN_W'(1))] <= fpu_res;
                    r_i <= r_i + PIDX_W'(1);
                end
            end
            S_DROP: begin
                // last point of the old stage is no longer needed
                for (int k = 0; k < MAX_POINTS - 1; k++) r_q[k] <= r_q[k + 1];
                r_len <= r_len - LEN_W'(1);
                r_m   <= r_m - PIDX_W'(1);
                r_i   <= '0;
            end
            S_HULL: begin
                if (r_hull == '0) begin
                    r_mn <= r_q[0];
                    r_mx <= r_q[0];
                end else begin
                    if (f_lt(r_q[0], r_mn))  r_mn <= r_q[0];
                    if (!f_lt(r_q[0], r_mx)) r_mx <= r_q[0];
                end
                r_hull <= r_hull + PIDX_W'(1);
            end
            S_OUT: begin
                if (out_free) begin
                    r_olo <= r_mn;
                    r_ohi <= r_mx;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: test/bezier_blossom_evaluator_unit_test.sv
// ----------------------------------------------------------------------------
// bezier_blossom_evaluator_unit_test
// self-checking bench for the bezier blossom evaluator unit
// ----------------------------------------------------------------------------
//  a directed table (point loads, extreme parameters, special values) runs
//  first, then random beats over a series of point counts; each curve value
//  and hull bound, predicted with native double arithmetic or taken from a
//  row's given answer, is compared field by field with the result channel
// ----------------------------------------------------------------------------
module bezier_blossom_evaluator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bbe_pkg::*;

    localparam int          CYCLE_LIMIT  = 5_000_000;
    localparam int          LONG_HOLD    = 2000;
    localparam int          DRAIN_CYCLES = 200;
    localparam int          CFG_SETTLE   = 20;
    localparam logic [63:0] D_ONE        = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] D_TWO        = 64'h4000_0000_0000_0000;
    localparam logic [63:0] D_TWO_HALF   = 64'h4004_0000_0000_0000;
    localparam logic [63:0] D_THREE      = 64'h4008_0000_0000_0000;
    localparam logic [63:0] D_FOUR       = 64'h4010_0000_0000_0000;
    localparam logic [63:0] D_HALF       = 64'h3FE0_0000_0000_0000;
    localparam logic [63:0] D_ZERO       = 64'h0;
    localparam logic [63:0] D_NEG_ZERO   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] D_INF        = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] D_QNAN       = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] D_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] D_MAX_FIN    = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] D_MIN_SUB    = 64'h0000_0000_0000_0001;

    typedef struct {
        logic [63:0] lower;
        logic [63:0] upper;
    } t_curve_res;

    typedef struct {
        t_func       func;
        logic [2:0]  idx;
        logic [63:0] value;
        logic [63:0] t_lo;
        logic [63:0] t_hi;
        bit          typed;
        logic [63:0] res_lo;
        logic [63:0] res_hi;
    } t_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_func;
    logic [2:0]  i_point_index;
    logic [63:0] i_point_value;
    logic [63:0] i_t_lower;
    logic [63:0] i_t_upper;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_result_lower;
    logic [63:0] o_result_upper;
    logic        i_cfg_wr_en;
    logic [3:0]  i_cfg_wr_data;

    bezier_blossom_evaluator_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_point_index  (i_point_index),
        .i_point_value  (i_point_value),
        .i_t_lower      (i_t_lower),
        .i_t_upper      (i_t_upper),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_lower (o_result_lower),
        .o_result_upper (o_result_upper),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    // mirror of the block state
    logic [63:0]  ctrl_pts [MAX_POINTS];
    logic [3:0]   pt_count;
    t_curve_res   curve_results_due [$];
    t_beat        dir_rows [$];
    int           fail_count;
    int           cycle_count;
    bit           hold_req;

    // ------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor: separately rounded lerp, de casteljau collapse, hull scan
    // ------------------------------------------------------------------
    function automatic real lerp(real a, real b, real t);
        real diff;
        real prod;
        diff = b - a;
        prod = t * diff;
        return a + prod;
    endfunction

    function automatic int points_in_use();
        int n;
        n = pt_count;
        if (n < 2) n = 2;
        if (n > MAX_POINTS) n = MAX_POINTS;
        return n;
    endfunction

    // last low_stages collapse stages take lo, earlier ones take hi
    function automatic real blossom_point(int n, real lo, real hi, int low_stages);
        real w [MAX_POINTS];
        real t;
        for (int i = 0; i < n; i++) w[i] = $bitstoreal(ctrl_pts[i]);
        for (int m = n - 1; m > 0; m--) begin
            t = (m <= low_stages) ? lo : hi;
            for (int i = 0; i < m; i++) w[i] = lerp(w[i], w[i + 1], t);
        end
        return w[0];
    endfunction

    // updates the mirror; returns 1 when the beat yields a result
    function automatic bit eval_curve(t_beat b, output t_curve_res r);
        int  n;
        real lo;
        real hi;
        real h;
        real mn;
        real mx;
        n  = points_in_use();
        lo = $bitstoreal(b.t_lo);
        hi = $bitstoreal(b.t_hi);
        r  = '{lower: '0, upper: '0};
        case (b.func)
            FUNC_LOAD: begin
                ctrl_pts[b.idx] = b.value;
                return 1'b0;
            end
            FUNC_VALUE: begin
                r.lower = $realtobits(blossom_point(n, lo, lo, 0));
                r.upper = r.lower;
                return 1'b1;
            end
            FUNC_BOUNDS: begin
                mn = blossom_point(n, lo, hi, 0);
                mx = mn;
                for (int i = 1; i < n; i++) begin
                    h = blossom_point(n, lo, hi, i);
                    // first of equal minima kept, last of equal maxima kept
                    if (h < mn) mn = h;
                    if (!(h < mx)) mx = h;
                end
                r.lower = $realtobits(mn);
                r.upper = $realtobits(mx);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // random operands
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand_double();
        logic [63:0] specials [8];
        logic [63:0] d;
        specials = '{D_ZERO, D_NEG_ZERO, D_INF, D_INF | D_NEG_ZERO, D_QNAN,
                     D_MAX_FIN, D_MIN_SUB, D_ONES};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: d = $realtobits((real'($urandom_range(0, 2000)) - 1000.0) / 64.0);
            5:             d = {$urandom, $urandom};
            6:             d = specials[$urandom_range(0, 7)];
            default: begin
                // any sign, any mantissa, any finite exponent: always finite
                d = {$urandom, $urandom};
                d[62:52] = 11'($urandom_range(0, 2046));
            end
        endcase
        return d;
    endfunction

    function automatic logic [63:0] rand_param();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: return $realtobits(real'($urandom_range(0, 1024)) / 1024.0);
            7:                   return $realtobits(real'($urandom_range(0, 3072)) / 1024.0 - 1.0);
            default:             return rand_double();
        endcase
    endfunction

    function automatic t_beat rand_beat();
        t_beat b;
        int    pick;
        pick     = $urandom_range(0, 99);
        b.func   = (pick < 40) ? FUNC_LOAD : (pick < 68) ? FUNC_VALUE :
                   (pick < 95) ? FUNC_BOUNDS : FUNC_NONE;
        b.idx    = 3'($urandom_range(0, 7));
        b.value  = (b.func == FUNC_LOAD) ? rand_double() : {$urandom, $urandom};
        b.t_lo   = rand_param();
        b.t_hi   = rand_param();
        b.typed  = 1'b0;
        b.res_lo = '0;
        b.res_hi = '0;
        return b;
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    task automatic send_beat(t_beat b);
        int         gap;
        int         pick;
        bit         has_res;
        t_curve_res r;
        pick = $urandom_range(0, 99);
        gap  = (pick < 60) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= b.func;
        i_point_index <= b.idx;
        i_point_value <= b.value;
        i_t_lower     <= b.t_lo;
        i_t_upper     <= b.t_hi;
        do @(posedge i_clk); while (!o_ready);
        has_res = eval_curve(b, r);
        if (has_res) begin
            // directed rows with a hand-written answer use it directly
            if (b.typed) r = '{lower: b.res_lo, upper: b.res_hi};
            curve_results_due.push_back(r);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (curve_results_due.size() != 0) @(posedge i_clk);
        // a load may still be in flight behind the last result
        repeat (CFG_SETTLE) @(posedge i_clk);
    endtask

    task automatic set_point_count(logic [3:0] cnt);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= cnt;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        pt_count      = cnt;
    endtask

    function automatic void add_row(t_func f, logic [2:0] idx, logic [63:0] v,
                                    logic [63:0] lo, logic [63:0] hi,
                                    bit typed, logic [63:0] rl, logic [63:0] rh);
        dir_rows.push_back('{f, idx, v, lo, hi, typed, rl, rh});
    endfunction

    // ------------------------------------------------------------------
    // result side: random back-pressure with one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        i_ready <= 1'b0;
        hold_req = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if ($urandom_range(0, 9) < 7) begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b0;
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(20, 100)) @(posedge i_clk);
                else
                    repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
    end

    // compare each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_curve_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (curve_results_due.size() == 0) begin
                $error("unexpected result beat lower=%h upper=%h",
                       o_result_lower, o_result_upper);
                fail_count++;
            end else begin
                want = curve_results_due.pop_front();
                if (o_result_lower !== want.lower) begin
                    $error("result_lower expected %h actual %h", want.lower, o_result_lower);
                    fail_count++;
                end
                if (o_result_upper !== want.upper) begin
                    $error("result_upper expected %h actual %h", want.upper, o_result_upper);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [3:0] phase_counts [14];
        int         n_items;
        fail_count    = 0;
        pt_count      = 4'd4;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_func        <= FUNC_LOAD;
        i_point_index <= '0;
        i_point_value <= '0;
        i_t_lower     <= '0;
        i_t_upper     <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        for (int i = 0; i < MAX_POINTS; i++) ctrl_pts[i] = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every slot is written before anything is evaluated
        add_row(FUNC_LOAD,   3'd0, D_ONE,      '0, '0, 0, '0, '0);
        add_row(FUNC_LOAD,   3'd1, D_TWO,      '0, '0, 0, '0, '0);
        add_row(FUNC_LOAD,   3'd2, D_THREE,    '0, '0, 0, '0, '0);
        add_row(FUNC_LOAD,   3'd3, D_FOUR,     '0, '0, 0, '0, '0);
        add_row(FUNC_LOAD,   3'd4, D_ZERO,     '0, '0, 0, '0, '0);
        add_row(FUNC_LOAD,   3'd5, D_ONES,     '0, '0, 0, '0, '0);
        add_row(FUNC_LOAD,   3'd6, D_NEG_ZERO, '0, '0, 0, '0, '0);
        add_row(FUNC_LOAD,   3'd7, D_INF,      '0, '0, 0, '0, '0);
        // straight line 1..4 at reset count of four: exact answers
        add_row(FUNC_VALUE,  3'd0, '0, D_ZERO, '0,     1, D_ONE,      D_ONE);
        add_row(FUNC_VALUE,  3'd7, '0, D_ONE,  '0,     1, D_FOUR,     D_FOUR);
        add_row(FUNC_VALUE,  3'd3, '0, D_HALF, D_ONES, 1, D_TWO_HALF, D_TWO_HALF);
        add_row(FUNC_BOUNDS, 3'd0, '0, D_ZERO, D_ONE,  1, D_ONE,      D_FOUR);
        add_row(FUNC_BOUNDS, 3'd5, '0, D_ONE,  D_ZERO, 1, D_ONE,      D_FOUR);
        // unused code takes a beat and returns nothing
        add_row(FUNC_NONE,   3'd7, D_ONES, D_ONES, D_ONES, 0, '0, '0);
        // infinite and nan parameters, signed zero and all-ones interval
        add_row(FUNC_VALUE,  3'd0, '0, D_INF,      '0,        0, '0, '0);
        add_row(FUNC_VALUE,  3'd0, '0, D_QNAN,     '0,        0, '0, '0);
        add_row(FUNC_BOUNDS, 3'd0, '0, D_NEG_ZERO, D_ONES,    0, '0, '0);
        // nan and huge control points, subnormal parameter
        add_row(FUNC_LOAD,   3'd0, D_ONES, '0, '0, 0, '0, '0);
        add_row(FUNC_VALUE,  3'd0, '0, D_HALF, '0,        0, '0, '0);
        add_row(FUNC_BOUNDS, 3'd0, '0, D_ZERO, D_ONE,     0, '0, '0);
        add_row(FUNC_LOAD,   3'd0, D_ZERO, '0, '0, 0, '0, '0);
        add_row(FUNC_LOAD,   3'd3, D_MAX_FIN, '0, '0, 0, '0, '0);
        add_row(FUNC_VALUE,  3'd0, '0, D_MAX_FIN, '0,     0, '0, '0);
        add_row(FUNC_BOUNDS, 3'd0, '0, D_MIN_SUB, D_ONE,  0, '0, '0);
        add_row(FUNC_BOUNDS, 3'd0, '0, D_MAX_FIN, D_INF,  0, '0, '0);

        foreach (dir_rows[k]) send_beat(dir_rows[k]);

        // point counts in use, clamped settings and the extremes among them
        phase_counts = '{4'd2, 4'd3, 4'd0, 4'd5, 4'd1, 4'd8, 4'd6,
                         4'd2, 4'd15, 4'd7, 4'd3, 4'd4, 4'd9, 4'd2};
        foreach (phase_counts[p]) begin
            set_point_count(phase_counts[p]);
            n_items = (points_in_use() <= 4) ? 40 : (points_in_use() < MAX_POINTS) ? 25 : 8;
            // receiver stalls for a long stretch while loads keep coming
            if (p == 0) hold_req = 1'b1;
            for (int k = 0; k < n_items; k++) send_beat(rand_beat());
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (curve_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
